// ===== hdl/bcdc_pkg.sv =====
package bcdc_pkg;

    localparam int unsigned DIGIT_W = 4;
    localparam logic [7:0] SEG_BLANK = 8'hFF;
    localparam logic [7:0] SEG_DOT = 8'h10;
    localparam logic [7:0] SEG_TABLE [10] = '{
        8'd18, 8'd159, 8'd56, 8'd28, 8'd149, 8'd84, 8'd80, 8'd31, 8'd16, 8'd20
    };

    localparam logic [1:0] SLOT_HOUR_TENS = 2'd0;
    localparam logic [1:0] SLOT_HOUR_UNITS = 2'd1;
    localparam logic [1:0] SLOT_MIN_TENS = 2'd2;
    localparam logic [1:0] SLOT_MIN_UNITS = 2'd3;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_SCAN = 1'b1;

    typedef struct packed {
        logic [1:0] tens;
        logic [3:0] units;
    } hours_t;

    typedef struct packed {
        logic [1:0] slot;
        logic [7:0] seg;
        logic       hour_inc;
        logic       minute_inc;
    } scan_out_t;

    function automatic logic [7:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [7:0] p;
        p = SEG_BLANK;
        if (d < DIGIT_W'(10))
            p = SEG_TABLE[d];
        return p;
    endfunction

    // 23 wraps to 00; 9 in the units carries into the tens
    function automatic hours_t hour_inc(input hours_t h);
        hours_t r;
        r = h;
        if (h.tens == 2'd2 && h.units == 4'd3) begin
            r.tens = 2'd0;
            r.units = 4'd0;
        end else if (h.units == 4'd9) begin
            r.units = 4'd0;
            r.tens = h.tens + 2'd1;
        end else begin
            r.units = h.units + 4'd1;
        end
        return r;
    endfunction

endpackage

// ===== hdl/bcdc_if.sv =====
interface bcdc_req_if;
    logic valid;
    logic ready;
    logic mode;
    logic button_hours_n;
    logic button_minutes_n;

    modport source (output valid, mode, button_hours_n, button_minutes_n, input ready);
    modport sink (input valid, mode, button_hours_n, button_minutes_n, output ready);
endinterface

interface bcdc_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] digit_slot;
    logic [7:0] segments;
    logic [1:0] hours_tens;
    logic [3:0] hours_units;
    logic [2:0] minutes_tens;
    logic [3:0] minutes_units;
    logic [2:0] seconds_tens;
    logic [3:0] seconds_units;
    logic [6:0] hundredths;

    modport source (output valid, digit_slot, segments, hours_tens, hours_units,
                    minutes_tens, minutes_units, seconds_tens, seconds_units,
                    hundredths, input ready);
    modport sink (input valid, digit_slot, segments, hours_tens, hours_units,
                  minutes_tens, minutes_units, seconds_tens, seconds_units,
                  hundredths, output ready);
endinterface

interface bcdc_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== hdl/bcdc_digit_cell.sv =====
module bcdc_digit_cell #(
    parameter int unsigned MODULUS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         inc,
    output logic [$clog2(MODULUS)-1:0]   value,
    output logic [$clog2(MODULUS)-1:0]   value_next,
    output logic                         carry
);
    localparam int unsigned W = $clog2(MODULUS);

    logic [W-1:0] value_reg;

    assign carry = inc && (value_reg == W'(MODULUS - 1));

    always_comb
    begin
        value_next = value_reg;
        if (carry)
            value_next = '0;
        else if (inc)
            value_next = value_reg + W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= '0;
        else
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== hdl/bcdc_hour_cell.sv =====
module bcdc_hour_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            inc_carry,
    input  logic            inc_button,
    output bcdc_pkg::hours_t value,
    output bcdc_pkg::hours_t value_next
);
    import bcdc_pkg::*;

    hours_t hours_reg;
    hours_t stage_a;

    // a button press and a minutes carry each add one hour; with both set it adds twice
    always_comb
    begin
        stage_a = inc_button ? hour_inc(hours_reg) : hours_reg;
        value_next = inc_carry ? hour_inc(stage_a) : stage_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hours_reg <= '0;
        else
            hours_reg <= value_next;
    end

    assign value = hours_reg;

endmodule

// ===== hdl/bcdc_scan.sv =====
module bcdc_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               button_hours_n,
    input  logic               button_minutes_n,
    input  bcdc_pkg::hours_t   hours,
    input  logic [2:0]         minutes_tens,
    input  logic [3:0]         minutes_units,
    input  logic [6:0]         hundredths,
    input  logic [6:0]         threshold,
    output bcdc_pkg::scan_out_t scan
);
    import bcdc_pkg::*;

    logic [1:0] slot_reg;
    logic [1:0] slot_next;
    logic       latch_h_reg;
    logic       latch_h_next;
    logic       latch_m_reg;
    logic       latch_m_next;
    logic       on_minutes;
    logic [7:0] seg;

    assign slot_next = step ? slot_reg + 2'd1 : slot_reg;
    assign on_minutes = step && (slot_next == SLOT_MIN_UNITS);

    // buttons are sampled only when the minutes digit is driven
    assign latch_h_next = on_minutes ? !button_hours_n : latch_h_reg;
    assign latch_m_next = on_minutes ? !button_minutes_n : latch_m_reg;

    always_comb
    begin
        seg = SEG_BLANK;
        if (step)
        begin
            unique case (slot_next)
                SLOT_HOUR_TENS:  seg = seg_of(DIGIT_W'(hours.tens));
                SLOT_HOUR_UNITS:
                begin
                    seg = seg_of(hours.units);
                    if (hundredths >= threshold)
                        seg = seg & ~SEG_DOT;
                    else
                        seg = seg | SEG_DOT;
                end
                SLOT_MIN_TENS:   seg = seg_of(DIGIT_W'(minutes_tens));
                SLOT_MIN_UNITS:  seg = seg_of(minutes_units);
                default:         seg = SEG_BLANK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= SLOT_MIN_UNITS;
            latch_h_reg <= 1'b0;
            latch_m_reg <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            latch_h_reg <= latch_h_next;
            latch_m_reg <= latch_m_next;
        end
    end

    assign scan.slot = slot_next;
    assign scan.seg = seg;
    assign scan.hour_inc = on_minutes && !button_hours_n && !latch_h_reg;
    assign scan.minute_inc = on_minutes && !button_minutes_n && !latch_m_reg;

`ifndef SYNTHESIS
    a_press_needs_minutes_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (scan.hour_inc || scan.minute_inc) |-> (step && slot_next == SLOT_MIN_UNITS))
        else $error("button increment outside the minutes slot");
    a_no_repeat_press: assert property (@(posedge clk) disable iff (!rst_n)
        scan.hour_inc |=> !scan.hour_inc)
        else $error("held hours button counted twice");
    a_tick_keeps_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(slot_reg))
        else $error("scan moved without a display step");
`endif

endmodule

// ===== hdl/bcd_clock_with_scan_display_top.sv =====
// 24-hour BCD clock with a four-digit multiplexed display. One request per clock:
// while ready: a tick request adds a hundredth, a scan request drives the next
// digit and, on the minutes digit, samples the two buttons. Each result is
// registered and shows in the cycle after acceptance; the whole digit carry
// ripple and the segment lookup are combinational. A new request is taken in
// the same cycle the held result is taken. The blink threshold resets to 50.
module bcd_clock_with_scan_display_top (
    input  logic clk,
    input  logic rst_n,
    bcdc_req_if.sink   req,
    bcdc_rsp_if.source rsp,
    bcdc_cfg_if.sink   cfg
);
    import bcdc_pkg::*;

    logic       accept;
    logic       tick;
    logic       step;
    logic [6:0] threshold_reg;

    logic [6:0] hund, hund_next;
    logic [3:0] su, su_next;
    logic [2:0] st, st_next;
    logic [3:0] mu, mu_next;
    logic [2:0] mt, mt_next;
    logic       c_hund, c_su, c_st, c_mu, c_mt;
    hours_t     hours, hours_next;
    scan_out_t  scan;

    logic       rsp_valid_reg;
    logic [1:0] slot_reg;
    logic [7:0] seg_reg;
    hours_t     hours_reg;
    logic [2:0] mt_reg;
    logic [3:0] mu_reg;
    logic [2:0] st_reg;
    logic [3:0] su_reg;
    logic [6:0] hund_reg;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept = req.valid && req.ready;
    assign tick = accept && (req.mode == MODE_TICK);
    assign step = accept && (req.mode == MODE_SCAN);

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= 7'd50;
        else if (cfg.valid)
            threshold_reg <= cfg.data;
    end

    bcdc_digit_cell #(.MODULUS(100)) u_hund (
        .clk(clk), .rst_n(rst_n), .inc(tick),
        .value(hund), .value_next(hund_next), .carry(c_hund));
    bcdc_digit_cell #(.MODULUS(10)) u_sec_units (
        .clk(clk), .rst_n(rst_n), .inc(c_hund),
        .value(su), .value_next(su_next), .carry(c_su));
    bcdc_digit_cell #(.MODULUS(6)) u_sec_tens (
        .clk(clk), .rst_n(rst_n), .inc(c_su),
        .value(st), .value_next(st_next), .carry(c_st));
    bcdc_digit_cell #(.MODULUS(10)) u_min_units (
        .clk(clk), .rst_n(rst_n), .inc(c_st || scan.minute_inc),
        .value(mu), .value_next(mu_next), .carry(c_mu));
    bcdc_digit_cell #(.MODULUS(6)) u_min_tens (
        .clk(clk), .rst_n(rst_n), .inc(c_mu),
        .value(mt), .value_next(mt_next), .carry(c_mt));
    bcdc_hour_cell u_hours (
        .clk(clk), .rst_n(rst_n), .inc_carry(c_mt), .inc_button(scan.hour_inc),
        .value(hours), .value_next(hours_next));

    bcdc_scan u_scan (
        .clk(clk), .rst_n(rst_n), .step(step),
        .button_hours_n(req.button_hours_n), .button_minutes_n(req.button_minutes_n),
        .hours(hours), .minutes_tens(mt), .minutes_units(mu),
        .hundredths(hund), .threshold(threshold_reg), .scan(scan));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg <= scan.slot;
            seg_reg <= scan.seg;
            hours_reg <= hours_next;
            mt_reg <= mt_next;
            mu_reg <= mu_next;
            st_reg <= st_next;
            su_reg <= su_next;
            hund_reg <= hund_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.digit_slot = slot_reg;
    assign rsp.segments = seg_reg;
    assign rsp.hours_tens = hours_reg.tens;
    assign rsp.hours_units = hours_reg.units;
    assign rsp.minutes_tens = mt_reg;
    assign rsp.minutes_units = mu_reg;
    assign rsp.seconds_tens = st_reg;
    assign rsp.seconds_units = su_reg;
    assign rsp.hundredths = hund_reg;

`ifndef SYNTHESIS
    a_hours_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !(hours.tens == 2'd3) && !(hours.tens == 2'd2 && hours.units > 4'd3))
        else $error("hours past 23");
    a_tick_blank: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> (rsp.segments == SEG_BLANK))
        else $error("tick result not blank");
    a_only_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        !(c_hund && (scan.hour_inc || scan.minute_inc)))
        else $error("tick carry and button press in the same step");
`endif

endmodule
